FILE: hdl/mcds_pkg.sv
package mcds_pkg;

   localparam int NUM_CHARS       = 40;
   localparam int NUM_ROWS        = 7;
   localparam int CHARS_PER_DEMUX = 16;
   localparam int PIXEL_BITS      = 5;

   localparam int STORE_DEPTH = NUM_ROWS * NUM_CHARS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int FRAME_TIME  = 4096;
   localparam int TIMER_W     = 13;

   localparam logic [1:0] REG_BRIGHTNESS    = 2'd0;
   localparam logic [1:0] REG_STROBE_TICKS  = 2'd1;
   localparam logic [1:0] REG_SCROLL_ENABLE = 2'd2;
   localparam logic [1:0] REG_SCROLL_PERIOD = 2'd3;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct packed {
      logic [4:0] column_data;
      logic [3:0] char_select;
      logic [2:0] enable_n;
      logic [6:0] row_n;
      logic       frame_start;
   } rsp_payload_type;

endpackage

FILE: hdl/multiplexed_char_display_scanner_top.sv
// Multiplexed character display scanner.
// Input stream (req_): each request is either a tick (req_tuser = 0) that
// advances the refresh scan by one time unit, or a pixel-row write
// (req_tuser = 1) into the row x character store. Every request yields
// exactly one response (rsp_) carrying the pins to drive: column data,
// char select, active-low demux enables, active-low row drive and the
// frame start flag (rsp_tuser).
// Configuration: csr_we/csr_index/csr_wdata write brightness, strobe
// ticks, scroll enable and scroll period; write only while idle.
// Throughput: one request per cycle unless a rsp_tready stall holds it. Each
// response passes the read stage (store read), then the output register,
// before rsp_tvalid rises.
// Reset: synchronous. After reset the store is cleared one entry a
// cycle, all 280 entries, with req_tready low; csr writes are still taken.
// Stall: with rsp_tready low, one more request is taken into the read
// stage, then req_tready drops until the output register drains.
module multiplexed_char_display_scanner_top
   import mcds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // write_row[2:0], write_column[8:3], write_pixels[13:9]
   input  logic        req_tuser,   // func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // column_data[4:0], char_select[8:5], enable_n[11:9],
                                    // row_n[18:12]
   output logic        rsp_tuser,   // frame_start

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   typedef enum logic [1:0] {PH_SEL, PH_DESEL, PH_ON, PH_OFF} phase_type;

   // scan state
   logic [2:0]          scan_row_ff, scan_row_in;
   logic [5:0]          scan_char_ff, scan_char_in;
   phase_type           scan_phase_ff, scan_phase_in;
   logic [TIMER_W-1:0]  phase_timer_ff, phase_timer_in;
   logic [7:0]          frame_count_ff, frame_count_in;
   logic [5:0]          scroll_offset_ff, scroll_offset_in;

   // registers
   logic [7:0] brightness_ff, strobe_ticks_ff, scroll_period_ff;
   logic       scroll_enable_ff;

   // clear pass
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // read stage
   logic            s1_valid_ff, s1_valid_in;
   logic            s1_show_ff;
   logic            s1_fwd_ff;
   logic [4:0]      s1_fwd_data_ff;
   rsp_payload_type s1_pay_ff;
   rsp_payload_type s1_out;

   // output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_pay_ff;

   logic accept, s1_move, is_write, tick;
   logic [2:0]        w_row;
   logic [5:0]        w_col;
   logic [4:0]        w_pix;
   logic [6:0]        char_sum;
   logic [5:0]        char_pos;
   logic [ADDR_W-1:0] rd_addr, wr_addr, ram_wr_addr;
   logic              wr_ok, ram_wr_en;
   logic [4:0]        ram_wr_data, ram_rd_data, s1_data;
   logic [TIMER_W-1:0] on_len, off_len, strobe_len, cur_len, timer_inc;
   rsp_payload_type   drv;

   assign w_row    = req_tdata[2:0];
   assign w_col    = req_tdata[8:3];
   assign w_pix    = req_tdata[13:9];
   assign s1_move  = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_ff && (!s1_valid_ff || s1_move);
   assign accept   = req_tvalid && req_tready;
   assign is_write = (req_tuser == FUNC_WRITE);
   assign tick     = accept && !is_write;

   // store addressing
   assign char_sum = 7'(scan_char_ff) + 7'(scroll_offset_ff);
   assign char_pos = (char_sum >= 7'(NUM_CHARS)) ? 6'(char_sum - 7'(NUM_CHARS))
                                                 : char_sum[5:0];
   assign rd_addr  = ADDR_W'(scan_row_ff) * ADDR_W'(NUM_CHARS) + ADDR_W'(char_pos);
   assign wr_addr  = ADDR_W'(w_row) * ADDR_W'(NUM_CHARS) + ADDR_W'(w_col);
   assign wr_ok    = accept && is_write && (w_row < 3'(NUM_ROWS)) && (w_col < 6'(NUM_CHARS));

   assign ram_wr_en   = clear_ff || wr_ok;
   assign ram_wr_addr = clear_ff ? clear_addr_ff : wr_addr;
   assign ram_wr_data = clear_ff ? 5'd0 : (w_pix & 5'((1 << PIXEL_BITS) - 1));

   mcds_ram #(
      .WIDTH (5),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign s1_data = !s1_show_ff ? 5'd0 : (s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data);

   always_comb begin
      s1_out             = s1_pay_ff;
      s1_out.column_data = s1_data;
   end

   // pin drive from current scan state
   always_comb begin
      drv             = '0;
      drv.enable_n    = 3'b111;
      drv.row_n       = 7'h7F;
      drv.frame_start = tick && scan_row_ff == 3'd0 && scan_char_ff == 6'd0 &&
                        scan_phase_ff == PH_SEL && phase_timer_ff == '0;
      if (scan_phase_ff == PH_SEL) begin
         drv.char_select = scan_char_ff[3:0];
         case (scan_char_ff[5:4])
            2'd0:    drv.enable_n = 3'b110;
            2'd1:    drv.enable_n = 3'b101;
            2'd2:    drv.enable_n = 3'b011;
            default: drv.enable_n = 3'b111;
         endcase
      end else if (scan_phase_ff == PH_ON && scan_row_ff < 3'd7) begin
         drv.row_n = ~(7'd1 << scan_row_ff);
      end
   end

   // scan advance
   assign on_len     = {1'b0, brightness_ff, 4'b0000};
   assign off_len    = TIMER_W'(FRAME_TIME) - on_len;
   assign strobe_len = (strobe_ticks_ff == 8'd0) ? TIMER_W'(1) : TIMER_W'(strobe_ticks_ff);
   assign timer_inc  = phase_timer_ff + TIMER_W'(1);

   always_comb begin
      case (scan_phase_ff)
         PH_ON:   cur_len = on_len;
         PH_OFF:  cur_len = off_len;
         default: cur_len = strobe_len;
      endcase
   end

   always_comb begin
      scan_row_in      = scan_row_ff;
      scan_char_in     = scan_char_ff;
      scan_phase_in    = scan_phase_ff;
      phase_timer_in   = phase_timer_ff;
      frame_count_in   = frame_count_ff;
      scroll_offset_in = scroll_offset_ff;
      if (tick) begin
         phase_timer_in = timer_inc;
         if (timer_inc >= cur_len) begin
            phase_timer_in = '0;
            case (scan_phase_ff)
               PH_SEL: begin
                  scan_phase_in = PH_DESEL;
               end
               PH_DESEL: begin
                  if (scan_char_ff < 6'(NUM_CHARS - 1)) begin
                     scan_char_in  = scan_char_ff + 6'd1;
                     scan_phase_in = PH_SEL;
                  end else begin
                     scan_char_in  = '0;
                     scan_phase_in = (on_len == '0) ? PH_OFF : PH_ON;
                  end
               end
               PH_ON: begin
                  scan_phase_in = PH_OFF;
               end
               default: begin
                  scan_phase_in = PH_SEL;
                  if (scan_row_ff < 3'(NUM_ROWS - 1)) begin
                     scan_row_in = scan_row_ff + 3'd1;
                  end else begin
                     scan_row_in = '0;
                     if (scroll_enable_ff) begin
                        if (frame_count_ff >= scroll_period_ff) begin
                           frame_count_in   = '0;
                           scroll_offset_in = (scroll_offset_ff == 6'(NUM_CHARS - 1)) ?
                                              6'd0 : scroll_offset_ff + 6'd1;
                        end else begin
                           frame_count_in = frame_count_ff + 8'd1;
                        end
                     end
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + ADDR_W'(1);
         if (clear_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
      s1_valid_in = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff      <= '0;
         scan_char_ff     <= '0;
         scan_phase_ff    <= PH_SEL;
         phase_timer_ff   <= '0;
         frame_count_ff   <= '0;
         scroll_offset_ff <= '0;
         brightness_ff    <= 8'd16;
         strobe_ticks_ff  <= 8'd1;
         scroll_enable_ff <= 1'b0;
         scroll_period_ff <= 8'd30;
         clear_ff         <= 1'b1;
         clear_addr_ff    <= '0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         scan_row_ff      <= scan_row_in;
         scan_char_ff     <= scan_char_in;
         scan_phase_ff    <= scan_phase_in;
         phase_timer_ff   <= phase_timer_in;
         frame_count_ff   <= frame_count_in;
         scroll_offset_ff <= scroll_offset_in;
         clear_ff         <= clear_in;
         clear_addr_ff    <= clear_addr_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_BRIGHTNESS:    brightness_ff    <= csr_wdata;
               REG_STROBE_TICKS:  strobe_ticks_ff  <= csr_wdata;
               REG_SCROLL_ENABLE: scroll_enable_ff <= csr_wdata[0];
               REG_SCROLL_PERIOD: scroll_period_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pay_ff      <= drv;
         s1_show_ff     <= (scan_phase_ff == PH_SEL);
         s1_fwd_ff      <= wr_ok && (wr_addr == rd_addr);
         s1_fwd_data_ff <= ram_wr_data;
      end
      if (s1_move) begin
         out_pay_ff <= s1_out;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_pay_ff.row_n, out_pay_ff.enable_n,
                        out_pay_ff.char_select, out_pay_ff.column_data};
   assign rsp_tuser  = out_pay_ff.frame_start;

endmodule

FILE: hdl/mcds_ram.sv
module mcds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/tb_multiplexed_char_display_scanner_top.sv
module tb_multiplexed_char_display_scanner_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mcds_pkg::*;

   typedef enum logic [1:0] {
      SCAN_SELECT,
      SCAN_DESELECT,
      SCAN_ROW_ON,
      SCAN_ROW_OFF
   } scan_phase_type;

   localparam int QUIET_LIMIT = 5000;
   localparam int MAX_PRINTED = 30;
   localparam logic [6:0] ROWS_DARK  = 7'h7F;
   localparam logic [2:0] DEMUX_IDLE = 3'b111;

   class scan_pin_board;
      bit [4:0] pixel_rows [STORE_DEPTH];
      int unsigned row, chr, timer, frames, offset;
      scan_phase_type phase;
      int unsigned brightness, strobe, scroll_on, scroll_period;
      rsp_payload_type expected_pins[$];
      int errors;

      function new();
         foreach (pixel_rows[i]) pixel_rows[i] = '0;
         row = 0;
         chr = 0;
         timer = 0;
         frames = 0;
         offset = 0;
         phase = SCAN_SELECT;
         brightness = 16;
         strobe = 1;
         scroll_on = 0;
         scroll_period = 30;
         errors = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [7:0] value);
         case (index)
            REG_BRIGHTNESS:    brightness = value;
            REG_STROBE_TICKS:  strobe = value;
            REG_SCROLL_ENABLE: scroll_on = value[0];
            REG_SCROLL_PERIOD: scroll_period = value;
            default: ;
         endcase
      endfunction

      function int unsigned phase_length(scan_phase_type p);
         case (p)
            SCAN_ROW_ON:  return 16 * brightness;
            SCAN_ROW_OFF: return FRAME_TIME - 16 * brightness;
            default:      return (strobe == 0) ? 1 : strobe;
         endcase
      endfunction

      function rsp_payload_type pins(logic first);
         rsp_payload_type pin;
         int unsigned shown, demux;
         pin.column_data = '0;
         pin.char_select = '0;
         pin.enable_n    = DEMUX_IDLE;
         pin.row_n       = ROWS_DARK;
         pin.frame_start = first;
         if (phase == SCAN_SELECT && chr < NUM_CHARS && row < NUM_ROWS) begin
            shown = (chr + offset) % NUM_CHARS;
            demux = (chr / CHARS_PER_DEMUX) & 3;
            pin.column_data = pixel_rows[row * NUM_CHARS + shown];
            pin.char_select = 4'(chr % CHARS_PER_DEMUX);
            if (demux < 3) pin.enable_n = DEMUX_IDLE & ~(3'b001 << demux);
         end else if (phase == SCAN_ROW_ON && row < 7) begin
            pin.row_n = ROWS_DARK & ~(7'b1 << row);
         end
         return pin;
      endfunction

      function void close_frame();
         if (scroll_on == 0) return;
         if (frames >= scroll_period) begin
            frames = 0;
            offset = (offset + 1) % NUM_CHARS;
         end else begin
            frames = (frames + 1) & 8'hFF;
         end
      endfunction

      function void advance();
         timer++;
         if (timer < phase_length(phase)) return;
         timer = 0;
         case (phase)
            SCAN_SELECT: phase = SCAN_DESELECT;
            SCAN_DESELECT: begin
               if (chr + 1 < NUM_CHARS) begin
                  chr++;
                  phase = SCAN_SELECT;
               end else begin
                  chr = 0;
                  phase = (16 * brightness == 0) ? SCAN_ROW_OFF : SCAN_ROW_ON;
               end
            end
            SCAN_ROW_ON: phase = SCAN_ROW_OFF;
            default: begin
               phase = SCAN_SELECT;
               if (row + 1 < NUM_ROWS) begin
                  row++;
               end else begin
                  row = 0;
                  close_frame();
               end
            end
         endcase
      endfunction

      function void note_request(logic func, logic [2:0] wr_row, logic [5:0] wr_col,
                                 logic [4:0] wr_pix);
         logic first;
         if (func == FUNC_WRITE) begin
            if (wr_row < NUM_ROWS && wr_col < NUM_CHARS)
               pixel_rows[wr_row * NUM_CHARS + wr_col] = wr_pix;
            expected_pins.push_back(pins(1'b0));
         end else begin
            first = (row == 0 && chr == 0 && phase == SCAN_SELECT && timer == 0);
            expected_pins.push_back(pins(first));
            advance();
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
      endtask

      task check_pins(logic [23:0] data, logic first);
         rsp_payload_type want, got;
         got.column_data = data[4:0];
         got.char_select = data[8:5];
         got.enable_n    = data[11:9];
         got.row_n       = data[18:12];
         got.frame_start = first;
         if (expected_pins.size() == 0) begin
            report_mismatch($sformatf("response %h/%b with no request pending", data, first));
            return;
         end
         want = expected_pins.pop_front();
         if (got != want)
            report_mismatch($sformatf(
               "data %h/%h sel %h/%h en %b/%b row %b/%b start %b/%b (got/exp)",
               got.column_data, want.column_data, got.char_select, want.char_select,
               got.enable_n, want.enable_n, got.row_n, want.row_n,
               got.frame_start, want.frame_start));
      endtask

      function int pending();
         return expected_pins.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [7:0]  csr_wdata  = '0;

   scan_pin_board board;
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   multiplexed_char_display_scanner_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response check, receiver stall and watchdog
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_pins(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_multiplexed_char_display_scanner_top: FAIL");
         $finish;
      end
   end

   task automatic send_request(input logic func, input logic [2:0] wr_row,
                               input logic [5:0] wr_col, input logic [4:0] wr_pix);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, wr_pix, wr_col, wr_row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(func, wr_row, wr_col, wr_pix);
   endtask

   task automatic random_request(input int write_pct);
      logic       func;
      logic [2:0] r;
      logic [5:0] c;
      int         roll;
      func = ($urandom_range(99) < write_pct) ? FUNC_WRITE : FUNC_TICK;
      r = 3'($urandom_range(NUM_ROWS - 1));
      c = 6'($urandom_range(NUM_CHARS - 1));
      roll = $urandom_range(9);
      if (roll == 0) r = 3'd7;
      else if (roll == 1) c = 6'($urandom_range(63, NUM_CHARS));
      send_request(func, r, c, 5'($urandom_range(31)));
   endtask

   // mostly ticks until the scan sits in a phase with its timer at least min_timer
   task automatic tick_until(input scan_phase_type want, input int unsigned min_timer);
      int guard;
      guard = 0;
      while (!(board.phase == want && board.timer >= min_timer) && guard < 5000) begin
         random_request(20);
         guard++;
      end
   endtask

   // stop sending and wait for every pending response
   task automatic drain(input int settle);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] bright, input logic [7:0] strobe_len,
                                 input logic [7:0] scroll, input logic [7:0] period);
      logic [7:0] values [4];
      logic [1:0] regs [4];
      values = '{bright, strobe_len, scroll, period};
      regs   = '{REG_BRIGHTNESS, REG_STROBE_TICKS, REG_SCROLL_ENABLE, REG_SCROLL_PERIOD};
      drain(4);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= values[i];
         @(posedge clock);
         board.set_register(regs[i], values[i]);
      end
      csr_we <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, writes seen at once, out-of-range writes
      send_request(FUNC_TICK, 3'd0, 6'd0, 5'h00);
      send_request(FUNC_TICK, 3'd7, 6'd63, 5'h1F);
      send_request(FUNC_WRITE, 3'd0, 6'd1, 5'h0A);
      send_request(FUNC_WRITE, 3'd0, 6'd0, 5'h1F);
      send_request(FUNC_WRITE, 3'd6, 6'd39, 5'h15);
      send_request(FUNC_WRITE, 3'd0, 6'd16, 5'h11);
      send_request(FUNC_WRITE, 3'd0, 6'd32, 5'h1E);
      send_request(FUNC_WRITE, 3'd7, 6'd1, 5'h1F);
      send_request(FUNC_WRITE, 3'd0, 6'd40, 5'h1F);
      send_request(FUNC_WRITE, 3'd7, 6'd63, 5'h00);
      send_request(FUNC_WRITE, 3'd0, 6'd1, 5'h00);
      send_request(FUNC_WRITE, 3'd0, 6'd1, 5'h15);
      repeat (10) send_request(FUNC_TICK, 3'($urandom_range(7)), 6'($urandom_range(63)),
                               5'($urandom_range(31)));

      // partial fill of the store
      repeat (80) random_request(100);

      // shorten the select time while well into it
      apply_settings(8'd128, 8'd40, 8'd0, 8'd255);
      tick_until(SCAN_SELECT, 20);
      apply_settings(8'd128, 8'd3, 8'd1, 8'd255);
      repeat (20) random_request(35);

      // zero strobe, full brightness, then shorten the row-on time while well into it
      apply_settings(8'd255, 8'd0, 8'd1, 8'd0);
      tick_until(SCAN_ROW_ON, 20);
      apply_settings(8'd1, 8'd0, 8'd1, 8'd0);

      // shorten the row-off time while well into it
      tick_until(SCAN_ROW_OFF, 20);
      apply_settings(8'd255, 8'd0, 8'd1, 8'd0);
      send_request(FUNC_TICK, 3'd0, 6'd0, 5'h00);

      // zero brightness skips the row-on time
      apply_settings(8'd0, 8'd0, 8'd1, 8'd0);
      tick_until(SCAN_ROW_OFF, 20);
      apply_settings(8'd255, 8'd0, 8'd1, 8'd0);
      send_request(FUNC_TICK, 3'd0, 6'd0, 5'h00);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 24 : 0;
         stall_pct = (ph == 2) ? 66 : (ph == 3) ? 24 : 0;
         apply_settings(8'($urandom_range(255)), 8'($urandom_range(3)),
                        8'($urandom_range(1)), 8'($urandom_range(255)));
         for (int n = 0; n < 120; n++) begin
            if (n == 60 || $urandom_range(99) < 2) drain(0);
            random_request(35);
         end
      end

      drain(8);
      if (board.errors == 0) begin
         $display("tb_multiplexed_char_display_scanner_top: PASS");
      end else begin
         $display("tb_multiplexed_char_display_scanner_top: FAIL");
      end
      $finish;
   end

endmodule
